### hw/rtl/sevt_pkg.sv
// Shared types, widths and reset constants for the sensor event trigger.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package sevt_pkg;

  // Field widths
  localparam int DATA_W    = 16;
  localparam int ELAPSED_W = 8;
  localparam int CLEAR_W   = 3;
  localparam int FLAG_W    = 3;
  localparam int CFG_IDX_W = 3;

  // Stream bus widths (fields packed from bit 0, padded to whole bytes)
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 24;

  // Averaging window default
  localparam int AVG_TICKS_DEFAULT = 16;

  // Event flag bit positions, shared by flags and clear mask
  localparam int FLAG_FIRST  = 0;
  localparam int FLAG_LIGHT  = 1;
  localparam int FLAG_SECOND = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROX_FIRST_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROX_SECOND_LEVEL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COOLDOWN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_COOLDOWN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_COOLDOWN    = 3'd5;

  // Register reset values
  localparam logic [DATA_W-1:0] LIGHT_THRESHOLD_RST   = 16'd1000;
  localparam logic [DATA_W-1:0] PROX_FIRST_LEVEL_RST  = 16'd2000;
  localparam logic [DATA_W-1:0] PROX_SECOND_LEVEL_RST = 16'd5000;
  localparam logic [DATA_W-1:0] LIGHT_COOLDOWN_RST    = 16'd2000;
  localparam logic [DATA_W-1:0] FIRST_COOLDOWN_RST    = 16'd2500;
  localparam logic [DATA_W-1:0] SECOND_COOLDOWN_RST   = 16'd10000;

  // Startup hold-off on the light event
  localparam logic [DATA_W-1:0] LIGHT_HOLD_STARTUP = 16'd10000;

  typedef struct packed {
    logic [DATA_W-1:0] light_threshold;
    logic [DATA_W-1:0] proximity_first_level;
    logic [DATA_W-1:0] proximity_second_level;
    logic [DATA_W-1:0] light_cooldown_ms;
    logic [DATA_W-1:0] first_cooldown_ms;
    logic [DATA_W-1:0] second_cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic [CLEAR_W-1:0]   clear_mask;
    logic [DATA_W-1:0]    proximity_level;
    logic [DATA_W-1:0]    ambient_level;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] average_light;
    logic [FLAG_W-1:0] flags;
  } result_t;

  // Hold-off timer step, floors at zero
  function automatic logic [DATA_W-1:0] count_down(input logic [DATA_W-1:0] timer,
                                                   input logic [ELAPSED_W-1:0] step);
    logic [DATA_W-1:0] step_ext;
    step_ext = {{(DATA_W-ELAPSED_W){1'b0}}, step};
    if (timer <= step_ext) begin
      return '0;
    end
    return timer - step_ext;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/sevt_cfg.sv
// Configuration register bank: six 16-bit thresholds and hold-off reloads.
// Depends on sevt_pkg.
`default_nettype none

module sevt_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [sevt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [sevt_pkg::DATA_W-1:0]     cfg_wdata,
  output sevt_pkg::cfg_t                       cfg
);
  import sevt_pkg::*;

  // Indexed write; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.light_threshold        <= LIGHT_THRESHOLD_RST;
      cfg.proximity_first_level  <= PROX_FIRST_LEVEL_RST;
      cfg.proximity_second_level <= PROX_SECOND_LEVEL_RST;
      cfg.light_cooldown_ms      <= LIGHT_COOLDOWN_RST;
      cfg.first_cooldown_ms      <= FIRST_COOLDOWN_RST;
      cfg.second_cooldown_ms     <= SECOND_COOLDOWN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LIGHT_THRESHOLD:   cfg.light_threshold        <= cfg_wdata;
        REG_PROX_FIRST_LEVEL:  cfg.proximity_first_level  <= cfg_wdata;
        REG_PROX_SECOND_LEVEL: cfg.proximity_second_level <= cfg_wdata;
        REG_LIGHT_COOLDOWN:    cfg.light_cooldown_ms      <= cfg_wdata;
        REG_FIRST_COOLDOWN:    cfg.first_cooldown_ms      <= cfg_wdata;
        REG_SECOND_COOLDOWN:   cfg.second_cooldown_ms     <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sevt_avg.sv
// Running light average step: floor((avg*(N-1) + sample) / N).
// Combinational; depends on sevt_pkg.
`default_nettype none

module sevt_avg #(
  parameter int AVERAGE_TICKS = sevt_pkg::AVG_TICKS_DEFAULT
) (
  input  wire logic [sevt_pkg::DATA_W-1:0] avg_cur,
  input  wire logic [sevt_pkg::DATA_W-1:0] sample,
  output logic      [sevt_pkg::DATA_W-1:0] avg_next
);
  import sevt_pkg::*;

  // Rewritten as avg + floor((sample - avg) / N). The difference is lifted
  // by OFFSET (a multiple of N, at least 2^16) so the dividend stays positive,
  // and the division is a multiply by a rounded-up reciprocal, exact for any
  // dividend below 2^XW.
  localparam int    LOG2N    = $clog2(AVERAGE_TICKS);
  localparam int    OFFSET_Q = ((1 << DATA_W) + AVERAGE_TICKS - 1) / AVERAGE_TICKS;
  localparam int    OFFSET   = OFFSET_Q * AVERAGE_TICKS;
  localparam int    XW       = DATA_W + 2;
  localparam int    SHIFT    = XW + LOG2N;
  localparam int    MW       = XW + 1;
  localparam longint RECIP   = ((64'sd1 <<< SHIFT) + AVERAGE_TICKS - 1) / AVERAGE_TICKS;

  logic [XW-1:0]    dividend;
  logic [XW+MW-1:0] product;
  logic [XW-1:0]    quotient;
  logic [XW-1:0]    sum;

  always_comb begin
    dividend = {2'b00, sample} + XW'(OFFSET) - {2'b00, avg_cur};
    product  = {{MW{1'b0}}, dividend} * {{XW{1'b0}}, MW'(RECIP)};
    quotient = XW'(product >> SHIFT);
    sum      = {2'b00, avg_cur} + quotient - XW'(OFFSET_Q);
    avg_next = sum[DATA_W-1:0];
  end

endmodule

`default_nettype wire

### hw/rtl/sevt_trig.sv
// Event state: light average, three hold-off timers and sticky flags.
// Advances once per item; depends on sevt_pkg and sevt_avg.
`default_nettype none

module sevt_trig #(
  parameter int AVERAGE_TICKS = sevt_pkg::AVG_TICKS_DEFAULT
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           step,
  input  wire sevt_pkg::item_t item,
  input  wire sevt_pkg::cfg_t  cfg,
  output sevt_pkg::result_t   result
);
  import sevt_pkg::*;

  logic [DATA_W-1:0] light_average, light_average_next;
  logic [DATA_W-1:0] light_hold_timer, light_hold_timer_next;
  logic [DATA_W-1:0] first_hold_timer, first_hold_timer_next;
  logic [DATA_W-1:0] second_hold_timer, second_hold_timer_next;
  logic [FLAG_W-1:0] event_flags, event_flags_next;

  logic [DATA_W-1:0] light_dn, first_dn, second_dn;
  logic [FLAG_W-1:0] fire;
  logic [FLAG_W-1:0] flags_now;

  sevt_avg #(
    .AVERAGE_TICKS(AVERAGE_TICKS)
  ) u_avg (
    .avg_cur (light_average),
    .sample  (item.ambient_level),
    .avg_next(light_average_next)
  );

  // Count down, detect, reload
  always_comb begin
    light_dn  = count_down(light_hold_timer,  item.elapsed_ms);
    first_dn  = count_down(first_hold_timer,  item.elapsed_ms);
    second_dn = count_down(second_hold_timer, item.elapsed_ms);

    fire = '0;
    fire[FLAG_LIGHT]  = (light_average_next >= cfg.light_threshold) &&
                        (light_average < cfg.light_threshold) && (light_dn == '0);
    fire[FLAG_FIRST]  = (item.proximity_level > cfg.proximity_first_level) &&
                        (first_dn == '0);
    fire[FLAG_SECOND] = (item.proximity_level > cfg.proximity_second_level) &&
                        (second_dn == '0);

    light_hold_timer_next  = fire[FLAG_LIGHT]  ? cfg.light_cooldown_ms  : light_dn;
    first_hold_timer_next  = fire[FLAG_FIRST]  ? cfg.first_cooldown_ms  : first_dn;
    second_hold_timer_next = fire[FLAG_SECOND] ? cfg.second_cooldown_ms : second_dn;

    // Report before clearing
    flags_now        = event_flags | fire;
    event_flags_next = flags_now & ~item.clear_mask;

    result.flags         = flags_now;
    result.average_light = light_average_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_average     <= '0;
      light_hold_timer  <= LIGHT_HOLD_STARTUP;
      first_hold_timer  <= '0;
      second_hold_timer <= '0;
      event_flags       <= '0;
    end else if (step) begin
      light_average     <= light_average_next;
      light_hold_timer  <= light_hold_timer_next;
      first_hold_timer  <= first_hold_timer_next;
      second_hold_timer <= second_hold_timer_next;
      event_flags       <= event_flags_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sensor_event_trigger_with_cooldown_core.sv
// Top level of the sensor event trigger: stream ports, input and result registers.
// Depends on sevt_pkg, sevt_cfg and sevt_trig.
//
// Each input beat is one sensor tick. The tick sits in an input register,
// then the hold-off timers count down combinationally, the light average steps
// (a multiply by a constant reciprocal), the three event tests run and the
// flags, average and timers are written back; the result lands in an output
// register. Throughput is one beat per clock while the sink takes results,
// since the whole state update, averaging multiplier included, is
// combinational; a full result register that is not draining stalls the input.
// A result is held in the result register until taken. Configuration writes
// take effect at once and must only be made while no tick is in flight.
`default_nettype none

module sensor_event_trigger_with_cooldown_core #(
  parameter int AVERAGE_TICKS = sevt_pkg::AVG_TICKS_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // elapsed_ms[7:0], ambient_level[23:8], proximity_level[39:24], clear_mask[42:40]
  input  wire logic [sevt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // first_proximity_event[0], light_event[1], second_proximity_event[2],
  // average_light[18:3]
  output logic [sevt_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_we,
  input  wire logic [sevt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sevt_pkg::DATA_W-1:0]        cfg_wdata
);
  import sevt_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  result_t result;
  result_t out_result;
  logic    advance;

  sevt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .cfg      (cfg)
  );

  sevt_trig #(
    .AVERAGE_TICKS(AVERAGE_TICKS)
  ) u_trig (
    .clk   (clk),
    .rst   (rst),
    .step  (advance),
    .item  (in_item),
    .cfg   (cfg),
    .result(result)
  );

  // Handshake: move the held tick when the result slot is free or draining
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign m_axis_tdata = {{(OUT_TDATA_W-$bits(result_t)){1'b0}}, out_result};

  // Checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("processed tick produced no result");

  a_held_tick_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_item)))
    else $error("stalled tick lost or changed");

endmodule

`default_nettype wire

### verif/tb_sensor_event_trigger_with_cooldown_core.sv
// Self-checking testbench for sensor_event_trigger_with_cooldown_core.
// Depends on sevt_pkg and the core RTL; carries its own model of timers, average and flags.
`timescale 1ns / 1ps

module tb_sensor_event_trigger_with_cooldown_core;
  import sevt_pkg::*;

  localparam int CLK_PERIOD  = 4;
  localparam int AVG_WINDOW  = AVG_TICKS_DEFAULT;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_TICKS = 240;
  localparam int IDLE_SLACK  = 8;     // extra clocks waited once the queues are empty
  localparam int DRAIN_LIMIT = 2000;
  localparam int HOLD_AFTER  = 400;   // beats accepted before the long sink stall
  localparam int HOLD_CYCLES = 300;

  // Indexes past the register map; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [DATA_W-1:0]      cfg_wdata = '0;

  sensor_event_trigger_with_cooldown_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stimulus and expectation stores
  item_t   tick_q[$];
  result_t report_q[$];
  int      beats_sent = 0;
  int      beats_in = 0;
  int      fail_count = 0;
  int      src_gap = 0;
  int      src_calm = 0;
  int      sink_gap = 0;
  int      sink_calm = 0;
  bit      sink_hold = 1'b0;

  // Model state and register shadow
  cfg_t              cfg_shadow;
  logic [DATA_W-1:0] avg_light;
  logic [DATA_W-1:0] light_hold;
  logic [DATA_W-1:0] first_hold;
  logic [DATA_W-1:0] second_hold;
  logic [FLAG_W-1:0] evt_flags;

  function automatic logic [DATA_W-1:0] sat16(int v);
    if (v < 0) return '0;
    if (v > 65535) return 16'hFFFF;
    return DATA_W'(v);
  endfunction

  // Hold-off countdown, stops at zero
  function automatic logic [DATA_W-1:0] hold_step(logic [DATA_W-1:0] ms_left,
                                                  logic [ELAPSED_W-1:0] ms);
    return (ms_left > DATA_W'(ms)) ? ms_left - DATA_W'(ms) : '0;
  endfunction

  // Mostly back-to-back, some short gaps, rare long ones, occasional calm runs
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One tick of the detector: countdown, average, event tests, report, clear
  function automatic void advance_detector(item_t it);
    logic [DATA_W-1:0] prior;
    logic [31:0]       acc;
    result_t           rep;
    first_hold  = hold_step(first_hold, it.elapsed_ms);
    second_hold = hold_step(second_hold, it.elapsed_ms);
    light_hold  = hold_step(light_hold, it.elapsed_ms);
    prior = avg_light;
    acc = 32'(avg_light) * 32'(AVG_WINDOW - 1) + 32'(it.ambient_level);
    avg_light = DATA_W'(acc / 32'(AVG_WINDOW));
    if (avg_light >= cfg_shadow.light_threshold && prior < cfg_shadow.light_threshold &&
        light_hold == '0) begin
      evt_flags[FLAG_LIGHT] = 1'b1;
      light_hold = cfg_shadow.light_cooldown_ms;
    end
    if (it.proximity_level > cfg_shadow.proximity_first_level && first_hold == '0) begin
      evt_flags[FLAG_FIRST] = 1'b1;
      first_hold = cfg_shadow.first_cooldown_ms;
    end
    if (it.proximity_level > cfg_shadow.proximity_second_level && second_hold == '0) begin
      evt_flags[FLAG_SECOND] = 1'b1;
      second_hold = cfg_shadow.second_cooldown_ms;
    end
    rep.flags = evt_flags;
    rep.average_light = avg_light;
    report_q.push_back(rep);
    evt_flags = evt_flags & ~it.clear_mask;
  endfunction

  // Register write, one clock of cfg_we; shadow follows the register map
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LIGHT_THRESHOLD:   cfg_shadow.light_threshold = val;
      REG_PROX_FIRST_LEVEL:  cfg_shadow.proximity_first_level = val;
      REG_PROX_SECOND_LEVEL: cfg_shadow.proximity_second_level = val;
      REG_LIGHT_COOLDOWN:    cfg_shadow.light_cooldown_ms = val;
      REG_FIRST_COOLDOWN:    cfg_shadow.first_cooldown_ms = val;
      REG_SECOND_COOLDOWN:   cfg_shadow.second_cooldown_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(input cfg_t c);
    write_reg(REG_LIGHT_THRESHOLD, c.light_threshold);
    write_reg(REG_PROX_FIRST_LEVEL, c.proximity_first_level);
    write_reg(REG_PROX_SECOND_LEVEL, c.proximity_second_level);
    write_reg(REG_LIGHT_COOLDOWN, c.light_cooldown_ms);
    write_reg(REG_FIRST_COOLDOWN, c.first_cooldown_ms);
    write_reg(REG_SECOND_COOLDOWN, c.second_cooldown_ms);
  endtask

  task automatic queue_tick(input logic [ELAPSED_W-1:0] el, input logic [DATA_W-1:0] amb,
                            input logic [DATA_W-1:0] prox, input logic [CLEAR_W-1:0] clr);
    item_t it;
    it.elapsed_ms = el;
    it.ambient_level = amb;
    it.proximity_level = prox;
    it.clear_mask = clr;
    tick_q.push_back(it);
  endtask

  // Random ticks aimed at the current thresholds: the ambient level switches between
  // a dark and a bright regime so the average keeps crossing the light threshold
  task automatic queue_random_ticks(input int count);
    item_t it;
    int    r;
    int    lvl;
    bit    bright;
    bright = 1'b0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 24) == 0) bright = !bright;
      r = $urandom_range(0, 9);
      if (r < 6) it.elapsed_ms = ELAPSED_W'($urandom_range(0, 40));
      else if (r < 8) it.elapsed_ms = ELAPSED_W'($urandom);
      else it.elapsed_ms = r[0] ? 8'hFF : 8'h00;
      r = $urandom_range(0, 9);
      lvl = int'(cfg_shadow.light_threshold);
      if (r == 0) it.ambient_level = DATA_W'($urandom);
      else if (r == 1) it.ambient_level = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      else if (bright) it.ambient_level = sat16(lvl + int'($urandom_range(0, 4000)));
      else it.ambient_level = sat16(lvl - int'($urandom_range(1, 4000)));
      r = $urandom_range(0, 9);
      if (r < 3) begin
        lvl = int'(cfg_shadow.proximity_first_level);
        it.proximity_level = sat16(lvl + int'($urandom_range(0, 4)) - 2);
      end else if (r < 5) begin
        lvl = int'(cfg_shadow.proximity_second_level);
        it.proximity_level = sat16(lvl + int'($urandom_range(0, 4)) - 2);
      end else if (r < 8) begin
        it.proximity_level = DATA_W'($urandom);
      end else begin
        it.proximity_level = DATA_W'($urandom_range(0, 1500));
      end
      it.clear_mask = $urandom_range(0, 1) ? CLEAR_W'(0) : CLEAR_W'($urandom);
      tick_q.push_back(it);
    end
  endtask

  // Wait until every queued tick is in and every result is out
  task automatic wait_idle();
    while (tick_q.size() != 0 || beats_in != beats_sent || report_q.size() != 0)
      @(posedge clk);
    repeat (IDLE_SLACK) @(posedge clk);
  endtask

  // Source driver: holds a beat until taken, then a random gap before the next
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || beats_in == beats_sent) begin
      if (src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap--;
      end else if (tick_q.size() != 0) begin
        s_axis_tdata  <= IN_TDATA_W'(tick_q.pop_front());
        s_axis_tvalid <= 1'b1;
        beats_sent++;
        src_gap = pick_gap(src_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink: random ready gaps, plus the long stall
  always @(negedge clk) begin
    if (rst || sink_hold) begin
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      m_axis_tready <= 1'b0;
      sink_gap--;
    end else begin
      m_axis_tready <= 1'b1;
      sink_gap = pick_gap(sink_calm);
    end
  end

  // Long sink stall while the source keeps offering, so the input backs up
  initial begin
    wait (beats_in >= HOLD_AFTER);
    @(posedge clk);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold = 1'b0;
  end

  // Monitor: check each result beat, then predict from each accepted input beat
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (report_q.size() == 0) begin
        $error("result beat with nothing expected: %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = report_q.pop_front();
        if (got.flags[FLAG_FIRST] !== want.flags[FLAG_FIRST]) begin
          $error("first_proximity_event: expected %0d, got %0d",
                 want.flags[FLAG_FIRST], got.flags[FLAG_FIRST]);
          fail_count++;
        end
        if (got.flags[FLAG_LIGHT] !== want.flags[FLAG_LIGHT]) begin
          $error("light_event: expected %0d, got %0d",
                 want.flags[FLAG_LIGHT], got.flags[FLAG_LIGHT]);
          fail_count++;
        end
        if (got.flags[FLAG_SECOND] !== want.flags[FLAG_SECOND]) begin
          $error("second_proximity_event: expected %0d, got %0d",
                 want.flags[FLAG_SECOND], got.flags[FLAG_SECOND]);
          fail_count++;
        end
        if (got.average_light !== want.average_light) begin
          $error("average_light: expected %0d, got %0d",
                 want.average_light, got.average_light);
          fail_count++;
        end
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      advance_detector(item_t'(s_axis_tdata[$bits(item_t)-1:0]));
      beats_in++;
    end
  end

  // Main sequence: reset, directed ticks, then random phases under several settings
  initial begin
    cfg_t c;
    int   waited;
    cfg_shadow.light_threshold        = LIGHT_THRESHOLD_RST;
    cfg_shadow.proximity_first_level  = PROX_FIRST_LEVEL_RST;
    cfg_shadow.proximity_second_level = PROX_SECOND_LEVEL_RST;
    cfg_shadow.light_cooldown_ms      = LIGHT_COOLDOWN_RST;
    cfg_shadow.first_cooldown_ms      = FIRST_COOLDOWN_RST;
    cfg_shadow.second_cooldown_ms     = SECOND_COOLDOWN_RST;
    avg_light   = '0;
    light_hold  = LIGHT_HOLD_STARTUP;
    first_hold  = '0;
    second_hold = '0;
    evt_flags   = '0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Short first-proximity hold-off, none on the second level
    c.light_threshold        = 16'd1000;
    c.proximity_first_level  = 16'd2000;
    c.proximity_second_level = 16'd5000;
    c.light_cooldown_ms      = 16'd2000;
    c.first_cooldown_ms      = 16'd300;
    c.second_cooldown_ms     = 16'd0;
    apply_config(c);
    write_reg(REG_SPARE_A, 16'h1234);
    write_reg(REG_SPARE_B, 16'hFFFF);

    // Directed ticks
    queue_tick(8'd0,   16'd0,     16'd0,     3'd0);  // all zero
    queue_tick(8'd255, 16'hFFFF,  16'd2000,  3'd0);  // at level: no event; light blocked by startup
    queue_tick(8'd255, 16'hFFFF,  16'd2001,  3'd0);  // first event, hold 300
    queue_tick(8'd255, 16'd0,     16'd5001,  3'd0);  // first held; second fires
    queue_tick(8'd45,  16'd0,     16'hFFFF,  3'd1);  // hold hits zero exactly; fire and clear
    queue_tick(8'd0,   16'd0,     16'd5000,  3'd7);  // second at level; clear all
    queue_tick(8'd200, 16'd32768, 16'd0,     3'd2);
    queue_tick(8'd255, 16'd0,     16'hFFFF,  3'd4);
    queue_tick(8'd1,   16'hFFFF,  16'd1,     3'd3);
    queue_tick(8'd128, 16'hAAAA,  16'h5555,  3'd5);
    queue_tick(8'd127, 16'h5555,  16'hAAAA,  3'd6);

    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin
          c.light_threshold        = LIGHT_THRESHOLD_RST;
          c.proximity_first_level  = PROX_FIRST_LEVEL_RST;
          c.proximity_second_level = PROX_SECOND_LEVEL_RST;
          c.light_cooldown_ms      = LIGHT_COOLDOWN_RST;
          c.first_cooldown_ms      = FIRST_COOLDOWN_RST;
          c.second_cooldown_ms     = SECOND_COOLDOWN_RST;
        end
        1: c = '0;
        2: c = '1;
        3: begin
          c.light_threshold        = DATA_W'($urandom_range(500, 60000));
          c.proximity_first_level  = DATA_W'($urandom_range(0, 30000));
          c.proximity_second_level = DATA_W'($urandom_range(30000, 65535));
          c.light_cooldown_ms      = DATA_W'($urandom_range(0, 300));
          c.first_cooldown_ms      = DATA_W'($urandom_range(0, 300));
          c.second_cooldown_ms     = DATA_W'($urandom_range(0, 300));
        end
        4: begin
          c = cfg_t'({$urandom, $urandom, $urandom});
          write_reg(REG_SPARE_A, DATA_W'($urandom));
        end
        default: begin
          c.light_threshold        = 16'd30000;
          c.proximity_first_level  = 16'd10000;
          c.proximity_second_level = 16'd40000;
          c.light_cooldown_ms      = 16'd1;
          c.first_cooldown_ms      = 16'd1000;
          c.second_cooldown_ms     = 16'hFFFF;
        end
      endcase
      apply_config(c);
      queue_random_ticks(PHASE_TICKS);
    end

    // All stimulus taken; let the results drain
    while (tick_q.size() != 0 || beats_in != beats_sent) @(posedge clk);
    waited = 0;
    while (report_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (IDLE_SLACK) @(posedge clk);
    if (report_q.size() != 0) begin
      $error("%0d expected results never arrived", report_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
